[rtl/core/dcta_pkg.sv]
// Shared types, character codes and the microcode ROM of the currency text accumulator.
// Used by dcta_useq, dcta_dpath and decimal_currency_text_accumulator_core.
`default_nettype none

package dcta_pkg;

  // Default digit counts of the running total
  localparam int INT_DIGITS_DEF  = 8;
  localparam int FRAC_DIGITS_DEF = 2;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Parser phase
  typedef enum logic [1:0] {
    PH_WAIT,
    PH_INT,
    PH_FRAC
  } phase_t;

  // Microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_ADD     = 4'd1;
  localparam step_t S_ADD_END = 4'd2;
  localparam step_t S_DOLLAR  = 4'd3;
  localparam step_t S_ZERO    = 4'd4;
  localparam step_t S_INT     = 4'd5;
  localparam step_t S_POINT   = 4'd6;
  localparam step_t S_FRAC    = 4'd7;
  localparam step_t S_NL      = 4'd8;

  // Which byte a step places in the output register
  typedef enum logic [2:0] {
    EM_NONE,
    EM_DOLLAR,
    EM_INT,
    EM_ZERO,
    EM_POINT,
    EM_FRAC,
    EM_NL
  } emit_t;

  // Datapath operation of a step
  typedef enum logic [2:0] {
    OP_DISPATCH,
    OP_NONE,
    OP_ADD,
    OP_ADD_END,
    OP_EMIT_INIT,
    OP_STEP_INT,
    OP_STEP_FRAC,
    OP_CLEAR
  } op_t;

  // Jump condition of a step
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_LEN_NZ,
    C_INT_MORE,
    C_FRAC_MORE,
    C_ADD_MORE
  } cond_t;

  // One control word
  typedef struct packed {
    emit_t emit;
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Datapath status toward the sequencer
  typedef struct packed {
    logic go_emit;
    logic go_add;
    logic len_nz;
    logic int_more;
    logic frac_more;
    logic add_more;
  } dp_status_t;

  // Microcode ROM
  function automatic uword_t rom_word(step_t s);
    uword_t w;
    w = '{emit: EM_NONE, op: OP_DISPATCH, cond: C_DISPATCH, target: S_IDLE};
    unique case (s)
      S_IDLE:    w = '{emit: EM_NONE,   op: OP_DISPATCH,  cond: C_DISPATCH,  target: S_IDLE};
      S_ADD:     w = '{emit: EM_NONE,   op: OP_ADD,       cond: C_ADD_MORE,  target: S_ADD};
      S_ADD_END: w = '{emit: EM_NONE,   op: OP_ADD_END,   cond: C_ALWAYS,    target: S_IDLE};
      S_DOLLAR:  w = '{emit: EM_DOLLAR, op: OP_EMIT_INIT, cond: C_LEN_NZ,    target: S_INT};
      S_ZERO:    w = '{emit: EM_ZERO,   op: OP_NONE,      cond: C_ALWAYS,    target: S_POINT};
      S_INT:     w = '{emit: EM_INT,    op: OP_STEP_INT,  cond: C_INT_MORE,  target: S_INT};
      S_POINT:   w = '{emit: EM_POINT,  op: OP_NONE,      cond: C_NEXT,      target: S_IDLE};
      S_FRAC:    w = '{emit: EM_FRAC,   op: OP_STEP_FRAC, cond: C_FRAC_MORE, target: S_FRAC};
      S_NL:      w = '{emit: EM_NL,     op: OP_CLEAR,     cond: C_ALWAYS,    target: S_IDLE};
      default:   w = '{emit: EM_NONE,   op: OP_DISPATCH,  cond: C_DISPATCH,  target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/core/decimal_currency_text_accumulator_core.sv]
// Decimal currency text accumulator: top level with the output register.
// Instantiates dcta_useq and dcta_dpath; depends on dcta_pkg.
//
// Usage:
//   Input stream s_axis_*: one transaction per text byte (tuser[0] = 0) or per
//   emit request (tuser[0] = 1). Bytes of "$d,ddd.dd" lines build an amount;
//   a newline adds it into the BCD running total.
//   Output stream m_axis_*: the formatted total, one byte per transaction,
//   "$", integer digits with commas, ".", cent digits, newline with tlast.
//   tuser[0] carries the sticky overflow flag as it stood at the emit.
// Timing:
//   A newline closing an amount runs the digit-serial BCD adder over all
//   INT_DIGITS + FRAC_DIGITS digits, one digit per cycle. An emit sends at most
//   15 bytes at default sizing; the step after the taken request loads the
//   first byte into the output register. The microcode sequencer runs one step
//   per cycle unless it waits for input or an output stall holds it, and takes
//   a new input only in its idle step.
// Reset: rst clears the total, the amount in entry, the parser and the flag.
// Stall: with m_axis_tready low and a byte pending, an emitting step holds
//   and the pending byte stays in the output register; nothing is dropped.
`default_nettype none

module decimal_currency_text_accumulator_core #(
  parameter int INT_DIGITS  = dcta_pkg::INT_DIGITS_DEF,
  parameter int FRAC_DIGITS = dcta_pkg::FRAC_DIGITS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] char_code
  input  wire  [0:0] s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,
  output logic [0:0] m_axis_tuser    // [0] overflow
);

  dcta_pkg::uword_t     uw;
  dcta_pkg::dp_status_t status;
  logic                 fire;
  logic                 in_fire;
  logic                 out_free;
  logic                 load;
  logic [7:0]           dp_char;
  logic                 dp_ovf;

  assign s_axis_tready = (uw.op == dcta_pkg::OP_DISPATCH);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign load          = fire && (uw.emit != dcta_pkg::EM_NONE);

  dcta_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .status   (status),
    .uw       (uw),
    .fire     (fire)
  );

  dcta_dpath #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .uw        (uw),
    .fire      (fire),
    .action    (s_axis_tuser[0]),
    .char_code (s_axis_tdata),
    .status    (status),
    .out_char  (dp_char),
    .overflow  (dp_ovf)
  );

  // Output register: load a byte or drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata    <= dp_char;
      m_axis_tlast    <= (uw.emit == dcta_pkg::EM_NL);
      m_axis_tuser[0] <= dp_ovf;
    end
  end

`ifndef SYNTHESIS
  // An emit request keeps the input closed in the following cycle
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> !s_axis_tready)
    else $error("input open right after an emit request");

  // The final byte of a total is the newline
  a_last_nl: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == dcta_pkg::CH_LF))
    else $error("tlast on a byte other than newline");

  // A newline never appears before the final byte
  a_nl_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata != dcta_pkg::CH_LF))
    else $error("newline without tlast");

  // The idle step never loads the output register
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !load)
    else $error("output loaded during the idle step");
`endif

endmodule

`default_nettype wire

[rtl/core/dcta_useq.sv]
// Microprogram sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on dcta_pkg for the control word, step codes and status struct.
`default_nettype none

module dcta_useq (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_fire,
  input  wire                  out_free,
  input  dcta_pkg::dp_status_t status,
  output dcta_pkg::uword_t     uw,
  output logic                 fire
);

  dcta_pkg::step_t step;
  dcta_pkg::step_t step_next;
  logic            taken;

  // Fetch the control word of the current step
  assign uw = dcta_pkg::rom_word(step);

  // Run the idle step on input, an emit step if the output is free, others at once
  always_comb begin
    if (uw.op == dcta_pkg::OP_DISPATCH) begin
      fire = in_fire;
    end else if (uw.emit == dcta_pkg::EM_NONE) begin
      fire = 1'b1;
    end else begin
      fire = out_free;
    end
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      dcta_pkg::C_NEXT:      taken = 1'b0;
      dcta_pkg::C_ALWAYS:    taken = 1'b1;
      dcta_pkg::C_LEN_NZ:    taken = status.len_nz;
      dcta_pkg::C_INT_MORE:  taken = status.int_more;
      dcta_pkg::C_FRAC_MORE: taken = status.frac_more;
      dcta_pkg::C_ADD_MORE:  taken = status.add_more;
      default:               taken = 1'b0;
    endcase
  end

  // Select the next step
  always_comb begin
    step_next = step;
    if (fire) begin
      if (uw.cond == dcta_pkg::C_DISPATCH) begin
        if (status.go_emit) begin
          step_next = dcta_pkg::S_DOLLAR;
        end else if (status.go_add) begin
          step_next = dcta_pkg::S_ADD;
        end else begin
          step_next = dcta_pkg::S_IDLE;
        end
      end else if (taken) begin
        step_next = uw.target;
      end else begin
        step_next = step + 4'd1;
      end
    end
  end

  // Hold the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dcta_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dcta_dpath.sv]
// Datapath: text parser, BCD amount and total registers, digit-serial adder and
// the byte selection for the formatted total. Depends on dcta_pkg.
`default_nettype none

module dcta_dpath #(
  parameter int INT_DIGITS  = dcta_pkg::INT_DIGITS_DEF,
  parameter int FRAC_DIGITS = dcta_pkg::FRAC_DIGITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  dcta_pkg::uword_t     uw,
  input  wire                  fire,
  input  wire                  action,
  input  wire  [7:0]           char_code,
  output dcta_pkg::dp_status_t status,
  output logic [7:0]           out_char,
  output logic                 overflow
);

  localparam int ALL = INT_DIGITS + FRAC_DIGITS;
  localparam int IW  = $clog2(ALL);
  localparam int LW  = $clog2(INT_DIGITS + 1);
  localparam int CW  = $clog2(FRAC_DIGITS + 1);

  logic [3:0]       total  [ALL];
  logic [3:0]       amount [ALL];
  dcta_pkg::phase_t phase;
  logic [CW-1:0]    cent_pos;
  logic [LW-1:0]    int_cnt;
  logic             ovf;
  logic [IW-1:0]    ptr;
  logic             carry;
  logic [1:0]       m3;
  logic             lead;
  logic             comma_done;

  logic [LW-1:0]    len;
  logic [1:0]       len_m3;
  logic [3:0]       t_dig;
  logic [4:0]       sum;
  logic [3:0]       sum_dig;
  logic             sum_cy;
  logic             is_digit;
  logic             comma_now;

  // Find the count of significant integer digits and its residue mod 3
  always_comb begin
    logic [1:0] c;
    c      = 2'd0;
    len    = '0;
    len_m3 = 2'd0;
    for (int i = 0; i < INT_DIGITS; i++) begin
      c = (c == 2'd2) ? 2'd0 : c + 2'd1;
      if (total[FRAC_DIGITS + i] != 4'd0) begin
        len    = LW'(i + 1);
        len_m3 = c;
      end
    end
  end

  // One BCD digit of the add
  assign t_dig   = total[ptr];
  assign sum     = {1'b0, t_dig} + {1'b0, amount[ptr]} + {4'd0, carry};
  assign sum_cy  = (sum > 5'd9);
  assign sum_dig = sum_cy ? 4'(sum - 5'd10) : sum[3:0];

  assign is_digit  = (char_code >= dcta_pkg::CH_ZERO) && (char_code <= dcta_pkg::CH_NINE);
  assign comma_now = (uw.emit == dcta_pkg::EM_INT) && !lead && (m3 == 2'd0) && !comma_done;

  // Status toward the sequencer
  always_comb begin
    status.go_emit   = action;
    status.go_add    = (phase != dcta_pkg::PH_WAIT) && (char_code == dcta_pkg::CH_LF);
    status.len_nz    = (len != '0);
    status.int_more  = comma_now || (ptr != IW'(FRAC_DIGITS));
    status.frac_more = (ptr != '0);
    status.add_more  = (ptr != IW'(ALL - 1));
  end

  // Select the output byte
  always_comb begin
    unique case (uw.emit)
      dcta_pkg::EM_DOLLAR: out_char = dcta_pkg::CH_DOLLAR;
      dcta_pkg::EM_INT:    out_char = comma_now ? dcta_pkg::CH_COMMA
                                                : (dcta_pkg::CH_ZERO | {4'd0, t_dig});
      dcta_pkg::EM_ZERO:   out_char = dcta_pkg::CH_ZERO;
      dcta_pkg::EM_POINT:  out_char = dcta_pkg::CH_POINT;
      dcta_pkg::EM_FRAC:   out_char = dcta_pkg::CH_ZERO | {4'd0, t_dig};
      dcta_pkg::EM_NL:     out_char = dcta_pkg::CH_LF;
      default:             out_char = 8'd0;
    endcase
  end

  assign overflow = ovf;

  // Run the datapath operation of the current step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALL; i++) begin
        total[i]  <= 4'd0;
        amount[i] <= 4'd0;
      end
      phase      <= dcta_pkg::PH_WAIT;
      cent_pos   <= '0;
      int_cnt    <= '0;
      ovf        <= 1'b0;
      ptr        <= '0;
      carry      <= 1'b0;
      m3         <= 2'd0;
      lead       <= 1'b0;
      comma_done <= 1'b0;
    end else if (fire) begin
      unique case (uw.op)
        dcta_pkg::OP_DISPATCH: begin
          if (!action) begin
            if (phase == dcta_pkg::PH_WAIT) begin
              // Start a new amount on a dollar sign
              if (char_code == dcta_pkg::CH_DOLLAR) begin
                for (int i = 0; i < ALL; i++) begin
                  amount[i] <= 4'd0;
                end
                cent_pos <= '0;
                int_cnt  <= '0;
                phase    <= dcta_pkg::PH_INT;
              end
            end else if (char_code == dcta_pkg::CH_LF) begin
              // Prepare the digit-serial add
              ptr   <= '0;
              carry <= 1'b0;
            end else if (char_code == dcta_pkg::CH_POINT) begin
              if (phase == dcta_pkg::PH_INT) begin
                phase <= dcta_pkg::PH_FRAC;
              end
            end else if (is_digit) begin
              if (phase == dcta_pkg::PH_INT) begin
                // Shift a new units digit in, drop extras
                if (int_cnt < LW'(INT_DIGITS)) begin
                  for (int i = ALL - 1; i > FRAC_DIGITS; i--) begin
                    amount[i] <= amount[i-1];
                  end
                  amount[FRAC_DIGITS] <= char_code[3:0];
                  int_cnt <= int_cnt + LW'(1);
                end
              end else if (cent_pos < CW'(FRAC_DIGITS)) begin
                amount[IW'(FRAC_DIGITS - 1) - IW'(cent_pos)] <= char_code[3:0];
                cent_pos <= cent_pos + CW'(1);
              end
            end
          end
        end
        dcta_pkg::OP_ADD: begin
          total[ptr] <= sum_dig;
          carry      <= sum_cy;
          ptr        <= ptr + IW'(1);
        end
        dcta_pkg::OP_ADD_END: begin
          if (carry) begin
            ovf <= 1'b1;
          end
          for (int i = 0; i < ALL; i++) begin
            amount[i] <= 4'd0;
          end
          cent_pos <= '0;
          int_cnt  <= '0;
          phase    <= dcta_pkg::PH_WAIT;
        end
        dcta_pkg::OP_EMIT_INIT: begin
          ptr        <= IW'(FRAC_DIGITS) + IW'(len) - IW'(1);
          m3         <= len_m3;
          lead       <= 1'b1;
          comma_done <= 1'b0;
        end
        dcta_pkg::OP_STEP_INT: begin
          if (comma_now) begin
            comma_done <= 1'b1;
          end else begin
            ptr        <= ptr - IW'(1);
            m3         <= (m3 == 2'd0) ? 2'd2 : m3 - 2'd1;
            comma_done <= 1'b0;
            lead       <= 1'b0;
          end
        end
        dcta_pkg::OP_STEP_FRAC: begin
          ptr <= ptr - IW'(1);
        end
        dcta_pkg::OP_CLEAR: begin
          for (int i = 0; i < ALL; i++) begin
            total[i] <= 4'd0;
          end
          ovf <= 1'b0;
        end
        dcta_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
